// ===== design/pst_pkg.sv =====
// ----------------------------------------------------------------------------
// pst_pkg: shared types and constants of the periodic timer slot table
// Field widths, mode, kind and status codes, and the default slot count.
// ----------------------------------------------------------------------------
`default_nettype none

package pst_pkg;

  localparam int NUM_SLOTS_DEFAULT = 16;

  localparam int MODE_W   = 2;
  localparam int PERIOD_W = 16;
  localparam int SLOT_W   = 4;
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 2;
  localparam int TOTAL_W  = 32;

  typedef logic [MODE_W-1:0]   mode_t;
  typedef logic [PERIOD_W-1:0] period_t;
  typedef logic [SLOT_W-1:0]   slot_t;
  typedef logic [KIND_W-1:0]   kind_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [TOTAL_W-1:0]  total_t;

  localparam mode_t MODE_TICK  = 2'd0;
  localparam mode_t MODE_SET   = 2'd1;
  localparam mode_t MODE_UNSET = 2'd2;

  localparam kind_t KIND_SET       = 2'd0;
  localparam kind_t KIND_EXPIRY    = 2'd1;
  localparam kind_t KIND_UNSET     = 2'd2;
  localparam kind_t KIND_TICK_DONE = 2'd3;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_RANGE = 2'd2;

endpackage

`default_nettype wire

// ===== design/pst_if.sv =====
// ----------------------------------------------------------------------------
// pst_if: valid/ready channels of the periodic timer slot table
// pst_cmd_if carries command words in, pst_evt_if carries result words out.
// ----------------------------------------------------------------------------
`default_nettype none

interface pst_cmd_if;
  import pst_pkg::*;

  logic    valid;
  logic    ready;
  mode_t   mode;
  period_t period;
  slot_t   target_slot;

  modport source (output valid, output mode, output period, output target_slot,
                  input ready);
  modport sink (input valid, input mode, input period, input target_slot,
                output ready);
endinterface

interface pst_evt_if;
  import pst_pkg::*;

  logic    valid;
  logic    ready;
  kind_t   kind;
  slot_t   slot_id;
  status_t status;
  total_t  tick_total;
  logic    last;

  modport source (output valid, output kind, output slot_id, output status,
                  output tick_total, output last, input ready);
  modport sink (input valid, input kind, input slot_id, input status,
                input tick_total, input last, output ready);
endinterface

`default_nettype wire

// ===== design/periodic_soft_timer_table.sv =====
// ----------------------------------------------------------------------------
// periodic_soft_timer_table: table of periodic timer slots
//
// Command words enter on cmd, result words leave on evt (valid/ready).
// A set word claims the lowest free slot, loads its period and clears its
// count; an unset word frees a slot. Each answers with one word in the cycle
// after acceptance. A tick word walks every slot, one slot per cycle while no
// expiry waits, through the slot RAM (read, advance, write back), emits an
// expiry word per active slot whose count reaches its period, and closes with
// a tick-done word carrying the 32-bit tick total. Mode 3 is taken and dropped.
// evt holds one registered word; a new command is taken only while the table is
// idle and that word is empty or leaving. A stalled receiver freezes the walk at
// the slot whose expiry waits, and the walk resumes when the word is taken.
// Reset frees all slots and zeroes the tick total at once; slot RAM contents
// are only used for active slots, so no clearing pass runs.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_soft_timer_table #(
  parameter int NUM_SLOTS = pst_pkg::NUM_SLOTS_DEFAULT
) (
  input  wire logic clk,
  input  wire logic rst,
  pst_cmd_if.sink   cmd,
  pst_evt_if.source evt
);
  import pst_pkg::*;

  localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CW = $clog2(NUM_SLOTS + 1);
  localparam int RW = 2 * PERIOD_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]           state;
  logic [NUM_SLOTS-1:0] active;
  total_t               tick_counter;
  logic [CW-1:0]        idx;
  logic                 pend;
  logic [SW-1:0]        pidx;

  logic    out_valid;
  kind_t   out_kind;
  slot_t   out_slot;
  status_t out_status;
  total_t  out_total;
  logic    out_last;

  // slot RAM: {period, count}
  logic          wr_en;
  logic [SW-1:0] wr_addr;
  logic [RW-1:0] wr_data;
  logic          rd_en;
  logic [RW-1:0] rd_data;

  logic          out_free;
  logic          acc;
  logic          free_found;
  logic [SW-1:0] free_idx;
  logic          tgt_ok;
  logic [SW-1:0] tgt_idx;
  period_t       cnt1;
  logic          match;
  logic          stall;
  logic          walk_wr;
  logic          idx_in;

  logic    ld;
  kind_t   ld_kind;
  slot_t   ld_slot;
  status_t ld_status;
  logic    ld_last;

  pst_ram #(
    .WIDTH (RW),
    .DEPTH (NUM_SLOTS)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (idx[SW-1:0]),
    .rd_data (rd_data)
  );

  assign out_free  = !out_valid || evt.ready;
  assign cmd.ready = (state == S_IDLE) && out_free;
  assign acc       = cmd.valid && cmd.ready;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!active[i]) begin
        free_found = 1'b1;
        free_idx   = SW'(i);
      end
    end
  end

  assign tgt_ok  = 32'(cmd.target_slot) < 32'(NUM_SLOTS);
  assign tgt_idx = SW'(cmd.target_slot);

  assign cnt1    = rd_data[PERIOD_W-1:0] + 1'b1;
  assign match   = cnt1 == rd_data[RW-1:PERIOD_W];
  assign stall   = pend && match && !out_free;
  assign walk_wr = (state == S_WALK) && pend && !stall;
  assign idx_in  = idx < CW'(NUM_SLOTS);
  assign rd_en   = (state == S_WALK) && !stall && idx_in;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pidx;
    wr_data = {rd_data[RW-1:PERIOD_W], (match ? PERIOD_W'(0) : cnt1)};
    if (walk_wr) begin
      wr_en = 1'b1;
    end else if (acc && cmd.mode == MODE_SET && free_found) begin
      wr_en   = 1'b1;
      wr_addr = free_idx;
      wr_data = {cmd.period, PERIOD_W'(0)};
    end
  end

  always_comb begin
    ld        = 1'b0;
    ld_kind   = KIND_TICK_DONE;
    ld_slot   = '0;
    ld_status = ST_OK;
    ld_last   = 1'b1;
    case (state)
      S_IDLE: begin
        if (acc && cmd.mode == MODE_SET) begin
          ld        = 1'b1;
          ld_kind   = KIND_SET;
          ld_slot   = free_found ? SLOT_W'(free_idx) : '0;
          ld_status = free_found ? ST_OK : ST_FULL;
        end else if (acc && cmd.mode == MODE_UNSET) begin
          ld        = 1'b1;
          ld_kind   = KIND_UNSET;
          ld_slot   = tgt_ok ? cmd.target_slot : '0;
          ld_status = tgt_ok ? ST_OK : ST_RANGE;
        end
      end
      S_WALK: begin
        if (walk_wr && match) begin
          ld      = 1'b1;
          ld_kind = KIND_EXPIRY;
          ld_slot = SLOT_W'(pidx);
          ld_last = 1'b0;
        end
      end
      S_DONE: begin
        ld = out_free;
      end
      default: begin
        ld = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      active       <= '0;
      tick_counter <= '0;
      idx          <= '0;
      pend         <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (ld) begin
        out_valid <= 1'b1;
      end else if (evt.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (acc && cmd.mode == MODE_TICK) begin
            tick_counter <= tick_counter + 1'b1;
            idx          <= '0;
            pend         <= 1'b0;
            state        <= S_WALK;
          end else if (acc && cmd.mode == MODE_SET && free_found) begin
            active[free_idx] <= 1'b1;
          end else if (acc && cmd.mode == MODE_UNSET && tgt_ok) begin
            active[tgt_idx] <= 1'b0;
          end
        end
        S_WALK: begin
          if (!stall) begin
            if (rd_en) begin
              pend <= active[idx[SW-1:0]];
              pidx <= idx[SW-1:0];
              idx  <= idx + 1'b1;
            end else begin
              pend <= 1'b0;
              if (!pend) begin
                state <= S_DONE;
              end
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      out_kind   <= ld_kind;
      out_slot   <= ld_slot;
      out_status <= ld_status;
      out_total  <= (acc && cmd.mode == MODE_TICK) ? tick_counter + 1'b1 : tick_counter;
      out_last   <= ld_last;
    end
  end

  assign evt.valid      = out_valid;
  assign evt.kind       = out_kind;
  assign evt.slot_id    = out_slot;
  assign evt.status     = out_status;
  assign evt.tick_total = out_total;
  assign evt.last       = out_last;

  a_pend_active : assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK && pend) |-> active[pidx])
    else $error("walk holds a read of a free slot");

  a_idx_bound : assert property (@(posedge clk) disable iff (rst)
    idx <= CW'(NUM_SLOTS))
    else $error("walk index past the table");

  a_tick_count : assert property (@(posedge clk) disable iff (rst)
    (acc && cmd.mode == MODE_TICK) |=> tick_counter == $past(tick_counter) + 1'b1)
    else $error("tick total not advanced");

  a_walk_write : assert property (@(posedge clk) disable iff (rst)
    (wr_en && state == S_WALK) |-> (pend && !stall))
    else $error("slot write during walk without a pending read");

  a_stall_hold : assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK && stall) |=> (pend && pidx == $past(pidx) && idx == $past(idx)))
    else $error("walk moved while an expiry waits");

endmodule

`default_nettype wire

// ===== design/pst_ram.sv =====
// ----------------------------------------------------------------------------
// pst_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module pst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  wr_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                      wr_data,
  input  wire logic                                  rd_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire
